>>> rtl/pidq_pkg.sv
`timescale 1ns / 1ps

package pidq_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_INSERT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SHIFT,
        S_PUT,
        S_DONE
    } state_t;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned POS_W  = 7;
    localparam int unsigned OCC_W  = 8;

endpackage

>>> rtl/pidq_if.sv
`timescale 1ns / 1ps

interface pidq_req_if;
    import pidq_pkg::*;

    logic                valid;
    logic                ready;
    cmd_t                command;
    logic [DATA_W-1:0]   value;
    logic [POS_W-1:0]    position;

    modport source (output valid, command, value, position, input ready);
    modport sink   (input valid, command, value, position, output ready);
endinterface

interface pidq_rsp_if;
    import pidq_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic [DATA_W-1:0]   data_out;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, status, data_out, occupancy, input ready);
    modport sink   (input valid, status, data_out, occupancy, output ready);
endinterface

>>> rtl/pidq_ram.sv
`timescale 1ns / 1ps

module pidq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/positional_insert_delete_queue.sv
// channel | dir | payload                          | handshake
// req     | in  | command, value, position         | valid / ready
// rsp     | out | status, data_out, occupancy      | valid / ready
//
// push, insert past the tail and every rejected command: done in S_IDLE; pop: ram read, S_POP
// remove at p: S_SHIFT moves count - p - 1 entries; insert at a < count: moves count - a
// entries + S_PUT (one entry moved per cycle through the single read and write port of the ram)
// rst_n clears count, head and the handshake state; the ram itself is never cleared
// req is taken while an earlier result still waits in the rsp register; a finished
// result that finds that register full is parked and holds off further items
`timescale 1ns / 1ps

module positional_insert_delete_queue #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    pidq_req_if.sink    req,
    pidq_rsp_if.source  rsp
);
    import pidq_pkg::*;

    localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

    // logical offset from head to ram address
    function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] head,
                                              input logic [CW-1:0] idx);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(idx);
        if (s >= (CW+1)'(CAPACITY))
        begin
            s = s - (CW+1)'(CAPACITY);
        end
        return AW'(s);
    endfunction

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic [CW-1:0]     wr_idx_reg, wr_idx_next;
    logic [CW-1:0]     left_reg, left_next;
    logic              down_reg, down_next;
    logic [DATA_W-1:0] ins_val_reg, ins_val_next;
    logic [CW-1:0]     ins_at_reg, ins_at_next;
    status_t           res_status_reg, res_status_next;
    logic [DATA_W-1:0] res_data_reg, res_data_next;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [OCC_W-1:0]  out_occ_reg;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    logic              fin;
    status_t           fin_status;
    logic [DATA_W-1:0] fin_data;
    logic              load_ok;
    logic              is_full, is_empty, pos_ge;
    logic [CW-1:0]     pos_cw, at_cw;

    pidq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign load_ok  = !out_valid_reg || rsp.ready;
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign pos_ge   = (CMPW'(req.position) >= CMPW'(count_reg));
    assign pos_cw   = CW'(req.position);
    assign at_cw    = pos_ge ? count_reg : pos_cw;

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.data_out  = out_data_reg;
    assign rsp.occupancy = out_occ_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        left_next       = left_reg;
        down_next       = down_reg;
        ins_val_next    = ins_val_reg;
        ins_at_next     = ins_at_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        fin             = 1'b0;
        fin_status      = ST_OK;
        fin_data        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (req.command)
                        CMD_PUSH:
                        begin
                            fin = 1'b1;
                            if (is_full)
                            begin
                                fin_status = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = to_phys(head_reg, count_reg);
                                ram_wdata  = req.value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (is_empty)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = head_reg;
                                head_next  = (head_reg == AW'(CAPACITY - 1)) ? '0
                                           : head_reg + AW'(1);
                                count_next = count_reg - CW'(1);
                                state_next = S_POP;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (is_empty)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end
                            else if (pos_ge)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_RANGE;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                if (pos_cw == count_reg - CW'(1))
                                begin
                                    // tail removed: nothing to close up
                                    fin = 1'b1;
                                end
                                else
                                begin
                                    ram_re      = 1'b1;
                                    ram_raddr   = to_phys(head_reg, pos_cw + CW'(1));
                                    wr_idx_next = pos_cw;
                                    rd_idx_next = pos_cw + CW'(2);
                                    left_next   = count_reg - pos_cw - CW'(2);
                                    down_next   = 1'b0;
                                    state_next  = S_SHIFT;
                                end
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (is_full)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                if (at_cw == count_reg)
                                begin
                                    fin       = 1'b1;
                                    ram_we    = 1'b1;
                                    ram_waddr = to_phys(head_reg, count_reg);
                                    ram_wdata = req.value;
                                end
                                else
                                begin
                                    // move the tail back first, working towards the gap
                                    ram_re       = 1'b1;
                                    ram_raddr    = to_phys(head_reg, count_reg - CW'(1));
                                    wr_idx_next  = count_reg;
                                    rd_idx_next  = count_reg - CW'(2);
                                    left_next    = count_reg - CW'(1) - at_cw;
                                    down_next    = 1'b1;
                                    ins_val_next = req.value;
                                    ins_at_next  = at_cw;
                                    state_next   = S_SHIFT;
                                end
                            end
                        end
                        default:
                        begin
                            fin = 1'b0;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                fin      = 1'b1;
                fin_data = ram_rdata;
            end
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = to_phys(head_reg, wr_idx_reg);
                ram_wdata = ram_rdata;
                if (left_reg != '0)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = to_phys(head_reg, rd_idx_reg);
                    rd_idx_next = down_reg ? rd_idx_reg - CW'(1) : rd_idx_reg + CW'(1);
                    wr_idx_next = down_reg ? wr_idx_reg - CW'(1) : wr_idx_reg + CW'(1);
                    left_next   = left_reg - CW'(1);
                end
                else if (down_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            S_PUT:
            begin
                fin       = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = to_phys(head_reg, ins_at_reg);
                ram_wdata = ins_val_reg;
            end
            S_DONE:
            begin
                fin        = 1'b1;
                fin_status = res_status_reg;
                fin_data   = res_data_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            if (load_ok)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                // rsp register still occupied: park the result
                res_status_next = fin_status;
                res_data_next   = fin_data;
                state_next      = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            if (fin && load_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        wr_idx_reg     <= wr_idx_next;
        left_reg       <= left_next;
        down_reg       <= down_next;
        ins_val_reg    <= ins_val_next;
        ins_at_reg     <= ins_at_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        if (fin && load_ok)
        begin
            out_status_reg <= fin_status;
            out_data_reg   <= fin_data;
            out_occ_reg    <= OCC_W'(count_next);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
    else $error("count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= AW'(CAPACITY - 1))
    else $error("head pointer out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.command == CMD_POP && !is_empty)
            |=> (state_reg == S_POP))
    else $error("pop did not wait for its read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.data_out == '0))
    else $error("rejected item carries data");

endmodule
